// ===== sv/rfifo_pkg.sv =====
// Shared definitions for the ring FIFO with peek and advance.
// Operation and status codes, fixed field widths and the controller command struct.
// No dependencies.
package rfifo_pkg;

   localparam int OP_W     = 3;
   localparam int WORD_W   = 64;
   localparam int OFFSET_W = 10;
   localparam int AMOUNT_W = 11;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 11;

   localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
   localparam logic [OP_W-1:0] OP_PEEK_AT = 3'd3;
   localparam logic [OP_W-1:0] OP_ADVANCE = 3'd4;
   localparam logic [OP_W-1:0] OP_COUNT   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic capture;
      logic execute;
   } rfifo_cmd_type;

endpackage

// ===== sv/rfifo_ctrl.sv =====
// Controller for the ring FIFO: sequences capture, execution and response.
// Depends on rfifo_pkg.
module rfifo_ctrl
   import rfifo_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_strobe,
   output rfifo_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign busy        = (state_ff == S_EXEC);
   assign rsp_strobe  = (state_ff == S_RESP);
   assign cmd.capture = start && !busy;
   assign cmd.execute = (state_ff == S_EXEC);

   always_comb begin
      unique case (state_ff)
         S_EXEC:  state_in = S_RESP;
         default: state_in = cmd.capture ? S_EXEC : S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/rfifo_dp.sv =====
// Datapath for the ring FIFO: request registers, pointers, slot memory and result registers.
// Depends on rfifo_pkg; driven by rfifo_ctrl commands.
module rfifo_dp
   import rfifo_pkg::*;
#(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 64
)(
   input  logic                clock,
   input  logic                reset,
   input  rfifo_cmd_type       cmd,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [WORD_W-1:0]   req_push_data,
   input  logic [OFFSET_W-1:0] req_peek_offset,
   input  logic [AMOUNT_W-1:0] req_advance_amount,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [WORD_W-1:0]   rsp_pop_data,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW = $clog2(2 * DEPTH);
   localparam int WW = (PW + 1 > 12) ? PW + 1 : 12;
   localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
   localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);
   localparam logic [WW-1:0] SPAN_W  = WW'(2 * DEPTH);

   logic [OP_W-1:0]       op_ff;
   logic [DATA_WIDTH-1:0] push_ff;
   logic [OFFSET_W-1:0]   offset_ff;
   logic [AMOUNT_W-1:0]   amount_ff;
   logic [PW-1:0]         head_ff, head_in;
   logic [PW-1:0]         tail_ff, tail_in;
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  data_ok_ff, data_ok_in;
   logic [WW-1:0]         occ_ff, occ_in;

   logic [WW-1:0] count_w;
   logic [WW-1:0] offset_w;
   logic [WW-1:0] amount_w;
   logic [WW-1:0] take_w;
   logic [PW-1:0] peek_ptr;
   logic [AW-1:0] rd_addr;
   logic          wr_en;

   function automatic logic [PW-1:0] wrap(input logic [WW-1:0] s);
      logic [WW-1:0] r;
      r = (s >= SPAN_W) ? s - SPAN_W : s;
      return r[PW-1:0];
   endfunction

   function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      r = (p >= DEPTH_P) ? p - DEPTH_P : p;
      return r[AW-1:0];
   endfunction

   always_comb begin
      count_w  = (tail_ff >= head_ff) ? WW'(tail_ff) - WW'(head_ff)
                                      : WW'(tail_ff) + SPAN_W - WW'(head_ff);
      offset_w = WW'(offset_ff);
      amount_w = WW'(amount_ff);
      take_w   = (amount_w > count_w) ? count_w : amount_w;
      peek_ptr = wrap(WW'(head_ff) + offset_w);
      rd_addr  = (op_ff == OP_PEEK_AT) ? slot_of(peek_ptr) : slot_of(head_ff);

      head_in    = head_ff;
      tail_in    = tail_ff;
      status_in  = ST_OK;
      data_ok_in = 1'b0;
      occ_in     = count_w;
      wr_en      = 1'b0;

      unique case (op_ff)
         OP_ENQUEUE: begin
            if (count_w >= DEPTH_W) begin
               status_in = ST_FULL;
            end else begin
               wr_en   = 1'b1;
               tail_in = wrap(WW'(tail_ff) + WW'(1));
               occ_in  = count_w + WW'(1);
            end
         end
         OP_DEQUEUE, OP_PEEK: begin
            if (count_w == '0) begin
               status_in = ST_EMPTY;
            end else begin
               data_ok_in = 1'b1;
               if (op_ff == OP_DEQUEUE) begin
                  head_in = wrap(WW'(head_ff) + WW'(1));
                  occ_in  = count_w - WW'(1);
               end
            end
         end
         OP_PEEK_AT: begin
            if (offset_w >= count_w) begin
               status_in = ST_EMPTY;
            end else begin
               data_ok_in = 1'b1;
            end
         end
         OP_ADVANCE: begin
            head_in = wrap(WW'(head_ff) + take_w);
            occ_in  = count_w - take_w;
            if (amount_w > count_w) begin
               status_in = ST_EMPTY;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         push_ff   <= req_push_data[DATA_WIDTH-1:0];
         offset_ff <= req_peek_offset;
         amount_ff <= req_advance_amount;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rd_data_ff <= mem[rd_addr];
         if (wr_en) begin
            mem[slot_of(tail_ff)] <= push_ff;
         end
         status_ff  <= status_in;
         data_ok_ff <= data_ok_in;
         occ_ff     <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else if (cmd.execute) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_pop_data  = data_ok_ff ? WORD_W'(rd_data_ff) : '0;
   assign rsp_occupancy = occ_ff[OCC_W-1:0];

endmodule

// ===== sv/ring_fifo_with_peek_and_advance.sv =====
// Ring FIFO with peek and advance: top level joining rfifo_ctrl and rfifo_dp.
// The result is strobed in the cycle after the execute cycle. busy covers the execute
// cycle only, so a new request can be accepted in the cycle that strobes the result.
// The receiver cannot stall.
// Synchronous reset empties the queue; slot contents are not cleared.
module ring_fifo_with_peek_and_advance
   import rfifo_pkg::*;
#(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 64
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [WORD_W-1:0]   req_push_data,
   input  logic [OFFSET_W-1:0] req_peek_offset,
   input  logic [AMOUNT_W-1:0] req_advance_amount,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [WORD_W-1:0]   rsp_pop_data,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   rfifo_cmd_type cmd;

   rfifo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   rfifo_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_operation      (req_operation),
      .req_push_data      (req_push_data),
      .req_peek_offset    (req_peek_offset),
      .req_advance_amount (req_advance_amount),
      .rsp_status         (rsp_status),
      .rsp_pop_data       (rsp_pop_data),
      .rsp_occupancy      (rsp_occupancy)
   );

endmodule

// ===== tb/ring_fifo_with_peek_and_advance_tb.sv =====
// Self-checking testbench for ring_fifo_with_peek_and_advance: directed and random
// operations, a fill to full, predicted results compared field by field.
// Depends on rfifo_pkg and the ring_fifo_with_peek_and_advance RTL.
module ring_fifo_with_peek_and_advance_tb;
   import rfifo_pkg::*;

   localparam int FIFO_DEPTH  = 1024;
   localparam int QUIET_TAIL  = 150;
   localparam int ITEM_TARGET = 1000;
   localparam logic [OP_W-1:0] OP_UNDEF_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNDEF_7 = 3'd7;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic [WORD_W-1:0]   push;
      logic [OFFSET_W-1:0] offset;
      logic [AMOUNT_W-1:0] amount;
      bit                  drain_first;
   } fifo_req_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   data;
      logic [OCC_W-1:0]    occ;
   } fifo_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_operation = OP_COUNT;
   logic [WORD_W-1:0]   req_push_data = '0;
   logic [OFFSET_W-1:0] req_peek_offset = '0;
   logic [AMOUNT_W-1:0] req_advance_amount = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [WORD_W-1:0]   rsp_pop_data;
   logic [OCC_W-1:0]    rsp_occupancy;

   fifo_req_type pending_reqs[$];
   fifo_rsp_type expected_rsps[$];
   fifo_req_type cur_req;
   fifo_rsp_type seen_exp;
   int           idle_left = 0;
   logic         drv_start;
   int           mismatch_count = 0;
   int           gen_occ = 0;

   // predictor state
   logic [WORD_W-1:0] shadow_words[FIFO_DEPTH];
   logic [OCC_W-1:0]  shadow_head = '0;
   logic [OCC_W-1:0]  shadow_tail = '0;

   ring_fifo_with_peek_and_advance #(
      .DEPTH(FIFO_DEPTH),
      .DATA_WIDTH(WORD_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_push_data(req_push_data),
      .req_peek_offset(req_peek_offset),
      .req_advance_amount(req_advance_amount),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_pop_data(rsp_pop_data),
      .rsp_occupancy(rsp_occupancy)
   );

   always #1 clock = ~clock;

   function automatic fifo_rsp_type fifo_step(fifo_req_type rq);
      fifo_rsp_type     r;
      logic [OCC_W-1:0] occ;
      logic [OCC_W-1:0] take;
      logic [9:0]       slot;
      occ = shadow_tail - shadow_head;
      r.status = ST_OK;
      r.data = '0;
      case (rq.op)
         OP_ENQUEUE: begin
            if (occ >= FIFO_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_words[shadow_tail[9:0]] = rq.push;
               shadow_tail = shadow_tail + 1'b1;
            end
         end
         OP_DEQUEUE, OP_PEEK: begin
            if (occ == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = shadow_words[shadow_head[9:0]];
               if (rq.op == OP_DEQUEUE) shadow_head = shadow_head + 1'b1;
            end
         end
         OP_PEEK_AT: begin
            if ({1'b0, rq.offset} >= occ) begin
               r.status = ST_EMPTY;
            end else begin
               slot = shadow_head[9:0] + rq.offset;
               r.data = shadow_words[slot];
            end
         end
         OP_ADVANCE: begin
            take = (rq.amount > occ) ? occ : rq.amount;
            shadow_head = shadow_head + take;
            if (rq.amount > occ) r.status = ST_EMPTY;
         end
         default: ;
      endcase
      r.occ = shadow_tail - shadow_head;
      return r;
   endfunction

   task automatic add_req(logic [OP_W-1:0] op, logic [WORD_W-1:0] push,
                          logic [OFFSET_W-1:0] offset, logic [AMOUNT_W-1:0] amount,
                          bit drain_first = 1'b0);
      fifo_req_type rq;
      rq.op = op;
      rq.push = push;
      rq.offset = offset;
      rq.amount = amount;
      rq.drain_first = drain_first;
      pending_reqs.push_back(rq);
      case (op)
         OP_ENQUEUE: if (gen_occ < FIFO_DEPTH) gen_occ++;
         OP_DEQUEUE: if (gen_occ > 0) gen_occ--;
         OP_ADVANCE: gen_occ = (amount > gen_occ) ? 0 : gen_occ - int'(amount);
         default: ;
      endcase
   endtask

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic add_random(int mode, bit drain_first);
      int                  r;
      int                  enq_pct;
      logic [OP_W-1:0]     op;
      logic [OFFSET_W-1:0] offset;
      logic [AMOUNT_W-1:0] amount;
      enq_pct = (mode == 0) ? 60 : (mode == 1) ? 20 : 40;
      r = $urandom_range(0, 99);
      if (r < enq_pct) begin
         op = OP_ENQUEUE;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 35) op = OP_DEQUEUE;
         else if (r < 45) op = OP_PEEK;
         else if (r < 75) op = OP_PEEK_AT;
         else if (r < 90) op = OP_ADVANCE;
         else if (r < 97) op = OP_COUNT;
         else op = ($urandom_range(0, 1) == 0) ? OP_UNDEF_6 : OP_UNDEF_7;
      end
      if ($urandom_range(0, 3) != 0)
         offset = OFFSET_W'($urandom_range(0, (gen_occ > 0) ? gen_occ - 1 : 0));
      else
         offset = OFFSET_W'($urandom_range(0, 1023));
      r = $urandom_range(0, 9);
      if (r < 6) amount = AMOUNT_W'($urandom_range(0, 3));
      else if (r < 9)
         amount = AMOUNT_W'($urandom_range(0, (gen_occ + 2 > 1024) ? 1024 : gen_occ + 2));
      else amount = AMOUNT_W'($urandom_range(0, 1024));
      add_req(op, rand_word(), offset, amount, drain_first);
   endtask

   task automatic build_stimulus();
      int mode;
      int n;
      add_req(OP_COUNT, '0, '0, '0);
      add_req(OP_DEQUEUE, '1, '0, '0);
      add_req(OP_PEEK, '0, '0, '0);
      add_req(OP_PEEK_AT, '0, '0, '0);
      add_req(OP_ADVANCE, '0, '0, 11'd0);
      add_req(OP_ADVANCE, '0, '0, 11'd1);
      add_req(OP_UNDEF_6, '1, '1, 11'd1024);
      add_req(OP_UNDEF_7, '1, '1, '1);
      add_req(OP_ENQUEUE, '0, '0, '0);
      add_req(OP_ENQUEUE, '1, '1, '1);
      add_req(OP_ENQUEUE, 64'h5555_5555_5555_5555, '0, '0);
      add_req(OP_ENQUEUE, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0);
      add_req(OP_PEEK, '0, '0, '0);
      add_req(OP_PEEK_AT, '0, 10'd0, '0);
      add_req(OP_PEEK_AT, '0, 10'd3, '0);
      add_req(OP_PEEK_AT, '0, 10'd4, '0);
      add_req(OP_PEEK_AT, '0, 10'd1023, '0);
      add_req(OP_DEQUEUE, '0, '0, '0);
      add_req(OP_ADVANCE, '0, '0, 11'd0);
      add_req(OP_ADVANCE, '0, '0, 11'd2);
      add_req(OP_ADVANCE, '0, '0, 11'd1024);
      add_req(OP_COUNT, '0, '0, '0);
      mode = 2;
      for (int i = 0; pending_reqs.size() < ITEM_TARGET; i++) begin
         if (i % 40 == 0) mode = $urandom_range(0, 2);
         if (i == 100) begin
            // fill past full, read the far end, wrap once, then clear exactly
            n = FIFO_DEPTH - gen_occ + 3;
            for (int k = 0; k < n; k++) add_req(OP_ENQUEUE, rand_word(), '0, '0, k == 0);
            add_req(OP_PEEK_AT, '0, 10'd1023, '0);
            add_req(OP_DEQUEUE, '0, '0, '0);
            add_req(OP_ENQUEUE, rand_word(), '0, '0);
            add_req(OP_ENQUEUE, rand_word(), '0, '0);
            add_req(OP_PEEK_AT, '0, 10'd1023, '0);
            add_req(OP_ADVANCE, '0, '0, 11'd1024);
            add_req(OP_COUNT, '0, '0, '0);
         end
         add_random(mode, (i == 0) || ($urandom_range(0, 99) == 0));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) expected_rsps.push_back(fifo_step(cur_req));
         if (!start || !busy) begin
            drv_start = 1'b0;
            if (idle_left > 0) begin
               idle_left--;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain_first && expected_rsps.size() > 0)) begin
               cur_req = pending_reqs.pop_front();
               req_operation <= cur_req.op;
               req_push_data <= cur_req.push;
               req_peek_offset <= cur_req.offset;
               req_advance_amount <= cur_req.amount;
               drv_start = 1'b1;
               if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                  idle_left = $urandom_range(1, 5);
            end
            start <= drv_start;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result transaction: status %0d data %h occupancy %0d",
                   rsp_status, rsp_pop_data, rsp_occupancy);
            mismatch_count++;
         end else begin
            seen_exp = expected_rsps.pop_front();
            if (rsp_status !== seen_exp.status) begin
               $error("rsp_status: expected %0d, got %0d", seen_exp.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_pop_data !== seen_exp.data) begin
               $error("rsp_pop_data: expected %h, got %h", seen_exp.data, rsp_pop_data);
               mismatch_count++;
            end
            if (rsp_occupancy !== seen_exp.occ) begin
               $error("rsp_occupancy: expected %0d, got %0d", seen_exp.occ, rsp_occupancy);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_reqs.size() != 0 || start) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #500000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
